FILE: rtl/core/fsws_pkg.sv
// Shared types and constants of the Fourier series waveform synthesizer.
`default_nettype none

package fsws_pkg;

    localparam int KIND_W     = 3;
    localparam int COUNT_W    = 11;
    localparam int STEPS_W    = 13;
    localparam int STEP_W     = 12;
    localparam int SUM_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HARMONICS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = 2'd2;

    localparam logic [KIND_W-1:0] WAVE_SQUARE   = 3'd0;
    localparam logic [KIND_W-1:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [KIND_W-1:0] WAVE_SAWTOOTH = 3'd2;
    localparam logic [KIND_W-1:0] WAVE_FULLWAVE = 3'd3;
    localparam logic [KIND_W-1:0] WAVE_SINE     = 3'd4;
    localparam logic [KIND_W-1:0] WAVE_COSINE   = 3'd5;
    localparam logic [KIND_W-1:0] WAVE_IMPULSE  = 3'd6;
    localparam logic [KIND_W-1:0] WAVE_UNUSED   = 3'd7;

    localparam logic [KIND_W-1:0]  RST_WAVE_KIND = WAVE_SQUARE;
    localparam logic [COUNT_W-1:0] RST_HARMONICS = 11'd60;
    localparam logic [STEPS_W-1:0] RST_STEPS     = 13'd400;

    localparam logic signed [15:0] Q15_MAX      = 16'sd32767;
    localparam logic signed [15:0] IMPULSE_COEF = 16'sd2086;
    localparam logic [16:0]        POLY_A       = 17'd102944;
    localparam logic [16:0]        POLY_B       = 17'd42047;
    localparam logic [16:0]        POLY_C       = 17'd4640;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_DIVS,
        OP_INIT,
        OP_SQ,
        OP_COEF,
        OP_CTAKE,
        OP_KMUL,
        OP_KDIV,
        OP_FTAKE,
        OP_CZ,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_M4,
        OP_MAC1,
        OP_MAC2,
        OP_MAC3,
        OP_MAC4,
        OP_NEXT,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic i_last;
        logic coef_div;
        logic coef_zero;
        logic csel;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/fsws_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module fsws_div
#(
    parameter int NW = 32,
    parameter int DW = 26
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [NW-1:0]      quo,
    output logic [DW-1:0]      rem
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fsws_ctrl.sv
// Sequencing state machine of the Fourier series waveform synthesizer.
`default_nettype none

module fsws_ctrl
    import fsws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_WDS,
        S_HARM,
        S_COEF,
        S_WCO,
        S_CHK,
        S_KDIV,
        S_WK,
        S_CZ,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_MAC1,
        S_MAC2,
        S_MAC3,
        S_MAC4,
        S_NEXT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    op_t    op;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                op         = OP_DIVS;
                state_next = S_WDS;
            end
            S_WDS:
            begin
                if (!sts.div_busy)
                begin
                    op         = OP_INIT;
                    state_next = S_HARM;
                end
            end
            S_HARM:
            begin
                if (sts.i_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    op         = OP_SQ;
                    state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                op         = OP_COEF;
                state_next = sts.coef_div ? S_WCO : S_CHK;
            end
            S_WCO:
            begin
                if (!sts.div_busy)
                begin
                    op         = OP_CTAKE;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.coef_zero)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    op         = OP_KMUL;
                    state_next = S_KDIV;
                end
            end
            S_KDIV:
            begin
                op         = OP_KDIV;
                state_next = S_WK;
            end
            S_WK:
            begin
                if (!sts.div_busy)
                begin
                    op         = OP_FTAKE;
                    state_next = S_CZ;
                end
            end
            S_CZ:
            begin
                op         = OP_CZ;
                state_next = S_M1;
            end
            S_M1:
            begin
                op         = OP_M1;
                state_next = S_M2;
            end
            S_M2:
            begin
                op         = OP_M2;
                state_next = S_M3;
            end
            S_M3:
            begin
                op         = OP_M3;
                state_next = S_M4;
            end
            S_M4:
            begin
                op         = OP_M4;
                state_next = sts.csel ? S_MAC1 : S_CZ;
            end
            S_MAC1:
            begin
                op         = OP_MAC1;
                state_next = S_MAC2;
            end
            S_MAC2:
            begin
                op         = OP_MAC2;
                state_next = S_MAC3;
            end
            S_MAC3:
            begin
                op         = OP_MAC3;
                state_next = S_MAC4;
            end
            S_MAC4:
            begin
                op         = OP_MAC4;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                op         = OP_NEXT;
                state_next = S_HARM;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign cmd.op   = op;
    assign cmd.take = (state_reg == S_IDLE) && in_valid;

endmodule

`default_nettype wire

FILE: rtl/core/fsws_dp.sv
// Datapath of the Fourier series waveform synthesizer: divider, multiplier and sums.
`default_nettype none

module fsws_dp
    import fsws_pkg::*;
#(
    parameter int MAX_HARMONICS    = 1024,
    parameter int MAX_STEPS        = 4096,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [STEP_W-1:0]   step_index,
    input  wire logic [KIND_W-1:0]   cfg_kind,
    input  wire logic [COUNT_W-1:0]  cfg_count,
    input  wire logic [STEPS_W-1:0]  cfg_steps,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic signed [SUM_W-1:0]  x_sum,
    output logic signed [SUM_W-1:0]  y_sum
);

    localparam int CW  = $clog2(MAX_HARMONICS + 1);
    localparam int SW  = $clog2(MAX_STEPS + 1);
    localparam int PW  = $clog2(MAX_STEPS);
    localparam int KW  = $clog2(SINE_TABLE_DEPTH);
    localparam int KPW = PW + KW + 2;
    localparam int CN0 = (2 * CW > 17) ? 2 * CW : 17;
    localparam int CNW = CN0 + 1;
    localparam int N1  = (CNW > STEP_W) ? CNW : STEP_W;
    localparam int NW  = (KPW > N1) ? KPW : N1;
    localparam int DW  = (2 * CW > SW + 1) ? 2 * CW : SW + 1;
    localparam int AW  = 33 + CW;
    localparam int MW  = 18;

    logic [STEP_W-1:0]     step_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [CW-1:0]         count_reg;
    logic [SW-1:0]         steps_reg;
    logic [CW-1:0]         i_reg;
    logic [PW-1:0]         p_reg;
    logic [PW-1:0]         s_reg;
    logic [2*CW-1:0]       sq_reg;
    logic signed [15:0]    ms_reg;
    logic signed [15:0]    mc_reg;
    logic [KPW-1:0]        kprod_reg;
    logic [17:0]           f_reg;
    logic                  csel_reg;
    logic [1:0]            q_reg;
    logic [16:0]           z_reg;
    logic [16:0]           z2_reg;
    logic [16:0]           t_reg;
    logic signed [15:0]    sn_reg;
    logic signed [15:0]    cs_reg;
    logic signed [AW-1:0]  ax_reg;
    logic signed [AW-1:0]  ay_reg;
    logic                  out_valid_reg;
    logic signed [SUM_W-1:0] x_reg;
    logic signed [SUM_W-1:0] y_reg;

    logic                  div_start;
    logic [NW-1:0]         div_num;
    logic [DW-1:0]         div_den;
    logic                  div_busy;
    logic [NW-1:0]         div_quo;
    logic [DW-1:0]         div_rem;

    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [2*MW-1:0] prod;

    logic                  c_div;
    logic                  c_two;
    logic                  c_to_mc;
    logic                  c_neg;
    logic [DW-1:0]         c_den;
    logic signed [15:0]    c_ms;
    logic signed [15:0]    c_mc;
    logic signed [15:0]    cval;
    logic signed [15:0]    cval_s;

    logic [KW:0]           kq;
    logic [KW-1:0]         kval;
    logic [17:0]           fa;
    logic [16:0]           rr;
    logic [15:0]           rsat;
    logic signed [15:0]    rval;
    logic [SW:0]           psum;
    logic [PW-1:0]         p_next;
    logic signed [AW-1:0]  pext;
    logic [SW-1:0]         steps_eff;
    logic [CW-1:0]         count_eff;

    function automatic logic signed [SUM_W-1:0] round_sat(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] v;
        logic signed [AW-1:0] r;
        v = a + AW'(8192);
        r = v >>> 14;
        if (r > AW'(signed'((1 << (SUM_W - 1)) - 1)))
        begin
            return {1'b0, {(SUM_W-1){1'b1}}};
        end
        else if (r < -AW'(signed'(1 << (SUM_W - 1))))
        begin
            return {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            return r[SUM_W-1:0];
        end
    endfunction

    fsws_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_comb
    begin
        if (cfg_steps == '0)
        begin
            steps_eff = SW'(1);
        end
        else if (32'(cfg_steps) > MAX_STEPS)
        begin
            steps_eff = SW'(MAX_STEPS);
        end
        else
        begin
            steps_eff = SW'(cfg_steps);
        end
        if (32'(cfg_count) > MAX_HARMONICS)
        begin
            count_eff = CW'(MAX_HARMONICS);
        end
        else
        begin
            count_eff = CW'(cfg_count);
        end
    end

    // Coefficient rule of the current harmonic.
    always_comb
    begin
        c_div   = 1'b0;
        c_two   = 1'b0;
        c_to_mc = 1'b0;
        c_neg   = 1'b0;
        c_den   = DW'(i_reg);
        c_ms    = '0;
        c_mc    = '0;
        case (kind_reg)
            WAVE_SQUARE:
            begin
                c_div = i_reg[0];
            end
            WAVE_TRIANGLE:
            begin
                c_div   = i_reg[0];
                c_to_mc = 1'b1;
                c_den   = DW'(sq_reg);
            end
            WAVE_SAWTOOTH:
            begin
                c_div = 1'b1;
                c_neg = ~i_reg[0];
            end
            WAVE_FULLWAVE:
            begin
                c_div   = ~i_reg[0];
                c_two   = 1'b1;
                c_to_mc = 1'b1;
                c_neg   = (CW > 1) ? ~i_reg[CW > 1 ? 1 : 0] : 1'b1;
                c_den   = DW'(sq_reg - 1'b1);
            end
            WAVE_SINE:
            begin
                if (i_reg == CW'(1))
                begin
                    c_ms = Q15_MAX;
                end
            end
            WAVE_IMPULSE:
            begin
                if (i_reg[0])
                begin
                    c_ms = ((CW > 1) && i_reg[CW > 1 ? 1 : 0]) ? -IMPULSE_COEF : IMPULSE_COEF;
                end
            end
            default:
            begin
                if (i_reg == CW'(1))
                begin
                    c_mc = Q15_MAX;
                end
            end
        endcase
    end

    always_comb
    begin
        if (div_quo > NW'(Q15_MAX))
        begin
            cval = Q15_MAX;
        end
        else
        begin
            cval = {1'b0, div_quo[14:0]};
        end
        cval_s = c_neg ? -cval : cval;
    end

    assign kq   = div_quo[KW:0];
    assign kval = (kq == (KW+1)'(SINE_TABLE_DEPTH)) ? '0 : kq[KW-1:0];

    always_comb
    begin
        div_start = 1'b0;
        div_num   = NW'(step_reg);
        div_den   = DW'(steps_reg);
        case (cmd.op)
            OP_DIVS:
            begin
                div_start = 1'b1;
            end
            OP_COEF:
            begin
                div_start = c_div;
                div_num   = NW'(c_two ? 18'h10000 : 18'h08000) + NW'(c_den >> 1);
                div_den   = c_den;
            end
            OP_KDIV:
            begin
                div_start = 1'b1;
                div_num   = NW'(kprod_reg) + NW'(steps_reg);
                div_den   = DW'({steps_reg, 1'b0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = MW'(i_reg);
                mul_b = MW'(i_reg);
            end
            OP_KMUL:
            begin
                mul_a = MW'(p_reg);
                mul_b = MW'(2 * SINE_TABLE_DEPTH);
            end
            OP_M1:
            begin
                mul_a = MW'(z_reg);
                mul_b = MW'(z_reg);
            end
            OP_M2:
            begin
                mul_a = MW'(POLY_C);
                mul_b = MW'(z2_reg);
            end
            OP_M3:
            begin
                mul_a = MW'(t_reg);
                mul_b = MW'(z2_reg);
            end
            OP_M4:
            begin
                mul_a = MW'(t_reg);
                mul_b = MW'(z_reg);
            end
            OP_MAC1:
            begin
                mul_a = MW'(mc_reg);
                mul_b = MW'(sn_reg);
            end
            OP_MAC2:
            begin
                mul_a = MW'(ms_reg);
                mul_b = MW'(cs_reg);
            end
            OP_MAC3:
            begin
                mul_a = MW'(ms_reg);
                mul_b = MW'(sn_reg);
            end
            OP_MAC4:
            begin
                mul_a = MW'(mc_reg);
                mul_b = MW'(cs_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign pext = AW'(prod);

    assign fa   = f_reg + (csel_reg ? 18'h10000 : 18'h00000);
    assign rr   = 17'((18'(prod[32:16]) + 18'd1) >> 1);
    assign rsat = (rr > 17'(Q15_MAX)) ? Q15_MAX : rr[15:0];
    assign rval = q_reg[1] ? -signed'(rsat) : signed'(rsat);

    assign psum   = (SW+1)'(p_reg) + (SW+1)'(s_reg);
    assign p_next = (psum >= (SW+1)'(steps_reg)) ? PW'(psum - (SW+1)'(steps_reg)) : PW'(psum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            step_reg  <= step_index;
            kind_reg  <= (cfg_kind == WAVE_UNUSED) ? WAVE_COSINE : cfg_kind;
            count_reg <= count_eff;
            steps_reg <= steps_eff;
        end
        case (cmd.op)
            OP_INIT:
            begin
                i_reg  <= CW'(1);
                p_reg  <= PW'(div_rem);
                s_reg  <= PW'(div_rem);
                ax_reg <= '0;
                ay_reg <= '0;
            end
            OP_SQ:
            begin
                sq_reg <= prod[2*CW-1:0];
            end
            OP_COEF:
            begin
                ms_reg <= c_ms;
                mc_reg <= c_mc;
            end
            OP_CTAKE:
            begin
                if (c_to_mc)
                begin
                    mc_reg <= cval_s;
                end
                else
                begin
                    ms_reg <= cval_s;
                end
            end
            OP_KMUL:
            begin
                kprod_reg <= prod[KPW-1:0];
            end
            OP_FTAKE:
            begin
                f_reg    <= 18'({kval, 18'b0} >> KW);
                csel_reg <= 1'b0;
            end
            OP_CZ:
            begin
                q_reg <= fa[17:16];
                z_reg <= fa[16] ? (17'h10000 - {1'b0, fa[15:0]}) : {1'b0, fa[15:0]};
            end
            OP_M1:
            begin
                z2_reg <= prod[32:16];
            end
            OP_M2:
            begin
                t_reg <= POLY_B - prod[32:16];
            end
            OP_M3:
            begin
                t_reg <= POLY_A - prod[32:16];
            end
            OP_M4:
            begin
                if (csel_reg)
                begin
                    cs_reg <= rval;
                end
                else
                begin
                    sn_reg <= rval;
                end
                csel_reg <= 1'b1;
            end
            OP_MAC1:
            begin
                ax_reg <= ax_reg + pext;
            end
            OP_MAC2:
            begin
                ax_reg <= ax_reg - pext;
            end
            OP_MAC3:
            begin
                ay_reg <= ay_reg + pext;
            end
            OP_MAC4:
            begin
                ay_reg <= ay_reg + pext;
            end
            OP_NEXT:
            begin
                i_reg <= i_reg + 1'b1;
                p_reg <= p_next;
            end
            OP_OUT:
            begin
                x_reg <= round_sat(ax_reg);
                y_reg <= round_sat(ay_reg);
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

    assign sts.div_busy  = div_busy;
    assign sts.i_last    = (i_reg >= count_reg);
    assign sts.coef_div  = c_div;
    assign sts.coef_zero = (ms_reg == '0) && (mc_reg == '0);
    assign sts.csel      = csel_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign x_sum     = x_reg;
    assign y_sum     = y_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fourier_series_waveform_synth.sv
// Top level of the Fourier series waveform synthesizer with its configuration registers.
// One transfer at a time: after acceptance the step is divided by the step count; then each
// harmonic slot forms its coefficient, through the divider where it is divided, and if it is
// not zero divides the phase, evaluates sine and cosine and adds to both sums.
// A new transfer is taken from the cycle after the result is issued; a stalled result waits.
// Reset returns the registers to square wave, 60 harmonics and 400 steps, and idles.
`default_nettype none

module fourier_series_waveform_synth
    import fsws_pkg::*;
#(
    parameter int MAX_HARMONICS    = 1024,
    parameter int MAX_STEPS        = 4096,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [STEP_W-1:0]      step_index,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [SUM_W-1:0]     x_sum,
    output logic signed [SUM_W-1:0]     y_sum
);

    logic [KIND_W-1:0]  wave_kind_reg;
    logic [COUNT_W-1:0] harmonic_count_reg;
    logic [STEPS_W-1:0] steps_per_cycle_reg;
    cmd_t               cmd;
    sts_t               sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_kind_reg       <= RST_WAVE_KIND;
            harmonic_count_reg  <= RST_HARMONICS;
            steps_per_cycle_reg <= RST_STEPS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WAVE_KIND: wave_kind_reg       <= cfg_data[KIND_W-1:0];
                CFG_HARMONICS: harmonic_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_STEPS:     steps_per_cycle_reg <= cfg_data[STEPS_W-1:0];
                default:       wave_kind_reg       <= wave_kind_reg;
            endcase
        end
    end

    fsws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsws_dp #(
        .MAX_HARMONICS    (MAX_HARMONICS),
        .MAX_STEPS        (MAX_STEPS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .step_index (step_index),
        .cfg_kind   (wave_kind_reg),
        .cfg_count  (harmonic_count_reg),
        .cfg_steps  (steps_per_cycle_reg),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .x_sum      (x_sum),
        .y_sum      (y_sum)
    );

endmodule

`default_nettype wire
